FILE: rtl/vlwp_pkg.sv
// Shared types and constants for the vector line walker with pincushion correction.
package vlwp_pkg;

  localparam int REG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 7;
  localparam logic [REG_IDX_BITS-1:0] REG_PINCUSHION_SHIFT = 1'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_STEP_SIZE = 1'd1;

  localparam logic [4:0] SHIFT_RESET = 5'd23;
  localparam logic [6:0] STEP_RESET = 7'd2;
  localparam logic [6:0] STEP_MAX = 7'd64;
  localparam int MAP_MARGIN = 38;

  localparam logic OP_LINE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [4:0] shift;
    logic [6:0] step;
  } cfg_t;

endpackage

FILE: rtl/vlwp_div.sv
// Iterative signed divider with truncating quotient, one quotient bit per cycle.
module vlwp_div #(
  parameter int NW = 25,
  parameter int DW = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic                 done,
  output logic signed [NW:0]   quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] nq_r;
  logic [DW-1:0] dmag_r;
  logic          neg_r;

  logic [NW-1:0] nmag;
  logic [DW-1:0] dmag;
  logic [DW:0]   rs;
  logic [DW:0]   diff;
  logic          ge;
  logic [NW:0]   qm;

  assign nmag = num[NW-1] ? (~num + 1'b1) : num;
  assign dmag = den[DW-1] ? (~den + 1'b1) : den;
  assign rs   = {rem_r, nq_r[NW-1]};
  assign diff = rs - {1'b0, dmag_r};
  assign ge   = (rs >= {1'b0, dmag_r});
  assign qm   = {1'b0, nq_r};
  assign quo  = neg_r ? (~qm + 1'b1) : qm;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      nq_r   <= nmag;
      dmag_r <= dmag;
      neg_r  <= num[NW-1] ^ den[DW-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : rs[DW-1:0];
      nq_r  <= {nq_r[NW-2:0], ge};
    end
  end

endmodule

FILE: rtl/vlwp_front.sv
// Input stage: accepts items, clamps endpoints and queues them for the walker.
module vlwp_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic signed [15:0]           in_x,
  input  logic signed [15:0]           in_y,
  input  logic [23:0]                  in_rgb,
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic                         q_op,
  output logic signed [COORD_BITS-1:0] q_x,
  output logic signed [COORD_BITS-1:0] q_y,
  output logic [23:0]                  q_rgb
);

  localparam int C = COORD_BITS;
  localparam int HALF = 1 << (C - 1);
  localparam int QD = 2;
  localparam int PW = $clog2(QD);

  logic                op_q  [QD];
  logic signed [C-1:0] x_q   [QD];
  logic signed [C-1:0] y_q   [QD];
  logic [23:0]         rgb_q [QD];

  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [PW:0]   cnt_r;

  logic                push;
  logic                pop;
  logic signed [C-1:0] cx;
  logic signed [C-1:0] cy;

  function automatic logic signed [C-1:0] clamp(input logic signed [15:0] v);
    logic signed [C-1:0] r;
    if (int'(v) < -HALF) r = C'(-HALF);
    else if (int'(v) > HALF - 1) r = C'(HALF - 1);
    else r = C'(v);
    return r;
  endfunction

  assign cx       = clamp(in_x);
  assign cy       = clamp(in_y);
  assign in_ready = (cnt_r != (PW+1)'(QD));
  assign q_valid  = (cnt_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_op     = op_q[rp_r];
  assign q_x      = x_q[rp_r];
  assign q_y      = y_q[rp_r];
  assign q_rgb    = rgb_q[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wp_r]  <= in_op;
      x_q[wp_r]   <= cx;
      y_q[wp_r]   <= cy;
      rgb_q[wp_r] <= in_rgb;
    end
  end

endmodule

FILE: rtl/vlwp_back.sv
// Walker sequencer: line setup, stepping, pincushion correction and output register.
module vlwp_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vlwp_pkg::cfg_t               cfg,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  logic                         q_op,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  input  logic [23:0]                  q_rgb,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [COORD_BITS-1:0]        out_x,
  output logic [COORD_BITS-1:0]        out_y,
  output logic [23:0]                  out_rgb,
  output logic                         out_last
);

  localparam int C = COORD_BITS;
  localparam int HALF = 1 << (C - 1);
  localparam int MAP_K = (1 << C) - 1 - vlwp_pkg::MAP_MARGIN;
  localparam int MAP_LO = vlwp_pkg::MAP_MARGIN - HALF;
  localparam int CODE_MAX = (1 << C) - 1;
  localparam int WW = C + 3;
  localparam int MA = 2 * C + 2;
  localparam int MB = C + 2;
  localparam int PW = MA + MB;
  localparam int NW = 2 * C + 1;
  localparam int DW = C + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAPXM = 4'd1;
  localparam logic [3:0] S_MAPXD = 4'd2;
  localparam logic [3:0] S_MAPYM = 4'd3;
  localparam logic [3:0] S_MAPYD = 4'd4;
  localparam logic [3:0] S_DIFF  = 4'd5;
  localparam logic [3:0] S_ICPM  = 4'd6;
  localparam logic [3:0] S_ICPD  = 4'd7;
  localparam logic [3:0] S_STEP  = 4'd8;
  localparam logic [3:0] S_MINM  = 4'd9;
  localparam logic [3:0] S_MIND  = 4'd10;
  localparam logic [3:0] S_SQY   = 4'd11;
  localparam logic [3:0] S_CUBX  = 4'd12;
  localparam logic [3:0] S_SQX   = 4'd13;
  localparam logic [3:0] S_CUBY  = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  localparam logic [1:0] MODE_XP = 2'd0;
  localparam logic [1:0] MODE_XN = 2'd1;
  localparam logic [1:0] MODE_YP = 2'd2;
  localparam logic [1:0] MODE_YN = 2'd3;

  logic [3:0]           state_r;
  logic                 started_r;
  logic                 active_r;
  logic [1:0]           mode_r;
  logic signed [C-1:0]  tgt_x_r, tgt_y_r;
  logic signed [C-1:0]  x1_r, y1_r;
  logic signed [C-1:0]  prev_x_r, prev_y_r;
  logic signed [WW-1:0] walk_x_r, walk_y_r;
  logic signed [C:0]    dx_r, dy_r;
  logic signed [WW-1:0] icpt_r;
  logic [23:0]          rgb_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] termx_r;
  logic                 last_r;
  logic                 ov_r;
  logic [C-1:0]         ox_r, oy_r;
  logic [23:0]          orgb_r;
  logic                 olast_r;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic                 mul_en;
  logic signed [NW-1:0] div_num;
  logic signed [DW-1:0] div_den;
  logic                 div_start;
  logic                 div_done;
  logic signed [NW:0]   div_quo;

  logic [C-1:0]         ux, uy;
  logic signed [WW-1:0] xh, yh;
  logic [6:0]           st;
  logic signed [WW-1:0] nm_x_up, nm_x_dn, nm_y_up, nm_y_dn;
  logic signed [WW-1:0] pe_x, pe_y;
  logic signed [C:0]    dx_nxt, dy_nxt;
  logic [C:0]           adx, ady;
  logic                 out_free;
  logic signed [PW+1:0] xc_f, yc_f;
  logic [NW:0]          map_sum;
  logic                 step_done;

  function automatic logic [C-1:0] sat_code(input logic signed [PW+1:0] v);
    logic [C-1:0] r;
    if (v < 0) r = '0;
    else if (v > (PW+2)'(CODE_MAX)) r = '1;
    else r = v[C-1:0];
    return r;
  endfunction

  assign ux = {~tgt_x_r[C-1], tgt_x_r[C-2:0]};
  assign uy = {~tgt_y_r[C-1], tgt_y_r[C-2:0]};
  assign xh = walk_x_r >>> 1;
  assign yh = walk_y_r >>> 1;
  assign st = (cfg.step == 7'd0) ? 7'd1 :
              (cfg.step > vlwp_pkg::STEP_MAX) ? vlwp_pkg::STEP_MAX : cfg.step;
  assign pe_x = WW'(prev_x_r);
  assign pe_y = WW'(prev_y_r);
  assign nm_x_up = walk_x_r + WW'(st);
  assign nm_x_dn = walk_x_r - WW'(st);
  assign nm_y_up = walk_y_r + WW'(st);
  assign nm_y_dn = walk_y_r - WW'(st);
  assign dx_nxt = (C+1)'(x1_r) - (C+1)'(prev_x_r);
  assign dy_nxt = (C+1)'(y1_r) - (C+1)'(prev_y_r);
  assign adx = dx_nxt[C] ? (~dx_nxt + 1'b1) : dx_nxt;
  assign ady = dy_nxt[C] ? (~dy_nxt + 1'b1) : dy_nxt;
  assign out_free = !ov_r || out_ready;
  assign xc_f = (PW+2)'(walk_x_r) - (PW+2)'(termx_r >>> cfg.shift) + (PW+2)'(HALF);
  assign yc_f = (PW+2)'(walk_y_r) - (PW+2)'(prod_r >>> cfg.shift) + (PW+2)'(HALF);

  // Division by 2^C - 1 as p + (p >> C) + 1, shifted down by C bits.
  assign map_sum = (NW+1)'(prod_r[NW-1:0]) + (NW+1)'(prod_r[NW-1:C]) + (NW+1)'(1);

  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_rgb   = orgb_r;
  assign out_last  = olast_r;

  always_comb begin
    step_done = 1'b0;
    case (mode_r)
      MODE_XP: step_done = (nm_x_up >= pe_x);
      MODE_XN: step_done = (nm_x_dn <= pe_x);
      MODE_YP: step_done = (nm_y_up >= pe_y);
      default: step_done = (nm_y_dn <= pe_y);
    endcase
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state_r)
      S_MAPXM: begin
        mul_a = MA'(ux);
        mul_b = MB'(MAP_K);
      end
      S_MAPYM: begin
        mul_a = MA'(uy);
        mul_b = MB'(MAP_K);
      end
      S_ICPM: begin
        if (!mode_r[1]) begin
          mul_a = -(MA'(dy_r));
          mul_b = MB'(x1_r);
        end else begin
          mul_a = -(MA'(dx_r));
          mul_b = MB'(y1_r);
        end
      end
      S_MINM: begin
        if (!mode_r[1]) begin
          mul_a = MA'(walk_x_r);
          mul_b = MB'(dy_r);
        end else begin
          mul_a = MA'(walk_y_r);
          mul_b = MB'(dx_r);
        end
      end
      S_SQY: begin
        mul_a = MA'(yh);
        mul_b = MB'(yh);
      end
      S_CUBX: begin
        mul_a = prod_r[MA-1:0];
        mul_b = MB'(xh);
      end
      S_SQX: begin
        mul_a = MA'(xh);
        mul_b = MB'(xh);
      end
      S_CUBY: begin
        mul_a = prod_r[MA-1:0];
        mul_b = MB'(yh);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    div_num   = prod_r[NW-1:0];
    div_den   = mode_r[1] ? DW'(dy_r) : DW'(dx_r);
    div_start = ((state_r == S_ICPD) || (state_r == S_MIND)) && !started_r;
  end

  vlwp_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      active_r  <= 1'b0;
      mode_r    <= MODE_XP;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      walk_x_r  <= '0;
      walk_y_r  <= '0;
      dx_r      <= '0;
      dy_r      <= '0;
      icpt_r    <= '0;
      rgb_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (div_start) started_r <= 1'b1;
      if (div_done) started_r <= 1'b0;
      if (ov_r && out_ready && state_r != S_FIN) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_op == vlwp_pkg::OP_LINE) begin
              tgt_x_r <= q_x;
              tgt_y_r <= q_y;
              rgb_r   <= q_rgb;
              state_r <= S_MAPXM;
            end else if (active_r) begin
              state_r <= S_STEP;
            end
          end
        end
        S_MAPXM: state_r <= S_MAPXD;
        S_MAPXD: begin
          x1_r    <= map_sum[2*C-1:C] + C'(MAP_LO);
          state_r <= S_MAPYM;
        end
        S_MAPYM: state_r <= S_MAPYD;
        S_MAPYD: begin
          y1_r    <= map_sum[2*C-1:C] + C'(MAP_LO);
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          dx_r <= dx_nxt;
          dy_r <= dy_nxt;
          if (adx >= ady) mode_r <= dx_nxt[C] ? MODE_XN : MODE_XP;
          else mode_r <= dy_nxt[C] ? MODE_YN : MODE_YP;
          state_r <= S_ICPM;
        end
        S_ICPM: begin
          if (!mode_r[1] && dx_r == '0) begin
            icpt_r   <= '0;
            walk_x_r <= pe_x;
            walk_y_r <= pe_y;
            prev_x_r <= x1_r;
            prev_y_r <= y1_r;
            active_r <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            state_r <= S_ICPD;
          end
        end
        S_ICPD: begin
          if (div_done) begin
            icpt_r   <= div_quo[WW-1:0] + (mode_r[1] ? WW'(x1_r) : WW'(y1_r));
            walk_x_r <= pe_x;
            walk_y_r <= pe_y;
            prev_x_r <= x1_r;
            prev_y_r <= y1_r;
            active_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        S_STEP: begin
          if (step_done) begin
            walk_x_r <= pe_x;
            walk_y_r <= pe_y;
            active_r <= 1'b0;
            last_r   <= 1'b1;
            state_r  <= S_SQY;
          end else begin
            case (mode_r)
              MODE_XP: walk_x_r <= nm_x_up;
              MODE_XN: walk_x_r <= nm_x_dn;
              MODE_YP: walk_y_r <= nm_y_up;
              default: walk_y_r <= nm_y_dn;
            endcase
            last_r  <= 1'b0;
            state_r <= S_MINM;
          end
        end
        S_MINM: begin
          if ((!mode_r[1] && dx_r == '0) || (mode_r[1] && dy_r == '0)) begin
            if (!mode_r[1]) walk_y_r <= icpt_r;
            else walk_x_r <= icpt_r;
            state_r <= S_SQY;
          end else begin
            state_r <= S_MIND;
          end
        end
        S_MIND: begin
          if (div_done) begin
            if (!mode_r[1]) walk_y_r <= div_quo[WW-1:0] + icpt_r;
            else walk_x_r <= div_quo[WW-1:0] + icpt_r;
            state_r <= S_SQY;
          end
        end
        S_SQY: state_r <= S_CUBX;
        S_CUBX: state_r <= S_SQX;
        S_SQX: begin
          termx_r <= prod_r;
          state_r <= S_CUBY;
        end
        S_CUBY: state_r <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            ov_r    <= 1'b1;
            ox_r    <= sat_code(xc_f);
            oy_r    <= sat_code(yc_f);
            orgb_r  <= rgb_r;
            olast_r <= last_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/vector_line_walker_pincushion_core.sv
// Top level of the vector line walker with cubic pincushion correction.
//
// The in_ stream carries commands: in_tuser is the op (line command or tick), in_tdata
// holds the endpoint and the line colour. A line command produces no output; each tick
// on an active line produces one corrected point on the out_ stream, with out_tlast set
// on the line's endpoint. Ticks with no line in progress are dropped silently.
// A two-entry queue sits between the input stage and the walker, so the input keeps
// accepting while the walker is busy or the output waits, until the queue is full.
// A line command makes one pass through the bit-serial divider for the intercept; the
// endpoint maps use a reciprocal multiply. A tick makes one divider pass for the minor
// coordinate and four multiplies for the correction. A zero-length line skips both
// divider passes, and the tick on a line's endpoint skips its divider pass.
// Results leave through an output register; when the receiver stalls, the walker holds
// its next point until that register is free, and the queue fills behind it.
// Synchronous reset clears the queue, the line state and the output register, and
// loads the default shift and step size. The cfg_ port writes a register on any cycle
// with cfg_we high.
module vector_line_walker_pincushion_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             cfg_we,
  input  logic [vlwp_pkg::REG_IDX_BITS-1:0]                cfg_index,
  input  logic [vlwp_pkg::CFG_DATA_BITS-1:0]               cfg_data,
  input  logic                                             in_tvalid,
  output logic                                             in_tready,
  // Fields from bit 0: target_x[15:0], target_y[15:0], red_in, green_in, blue_in.
  input  logic [55:0]                                      in_tdata,
  // Fields from bit 0: op.
  input  logic                                             in_tuser,
  output logic                                             out_tvalid,
  input  logic                                             out_tready,
  // Fields from bit 0: x_code, y_code, red_out, green_out, blue_out.
  output logic [((2*COORD_BITS+24+7)/8)*8-1:0]             out_tdata,
  output logic                                             out_tlast
);

  localparam int C = COORD_BITS;
  localparam int ODW = ((2 * C + 24 + 7) / 8) * 8;

  vlwp_pkg::cfg_t cfg_r;

  logic                q_valid;
  logic                q_ready;
  logic                q_op;
  logic signed [C-1:0] q_x;
  logic signed [C-1:0] q_y;
  logic [23:0]         q_rgb;
  logic [C-1:0]        o_x;
  logic [C-1:0]        o_y;
  logic [23:0]         o_rgb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shift <= vlwp_pkg::SHIFT_RESET;
      cfg_r.step  <= vlwp_pkg::STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vlwp_pkg::REG_PINCUSHION_SHIFT: cfg_r.shift <= cfg_data[4:0];
        vlwp_pkg::REG_STEP_SIZE:        cfg_r.step  <= cfg_data;
        default: ;
      endcase
    end
  end

  vlwp_front #(.COORD_BITS(C)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_x     (in_tdata[15:0]),
    .in_y     (in_tdata[31:16]),
    .in_rgb   ({in_tdata[39:32], in_tdata[47:40], in_tdata[55:48]}),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_op     (q_op),
    .q_x      (q_x),
    .q_y      (q_y),
    .q_rgb    (q_rgb)
  );

  vlwp_back #(.COORD_BITS(C)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_op      (q_op),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_rgb     (q_rgb),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (o_x),
    .out_y     (o_y),
    .out_rgb   (o_rgb),
    .out_last  (out_tlast)
  );

  assign out_tdata = ODW'({o_rgb[7:0], o_rgb[15:8], o_rgb[23:16], o_y, o_x});

endmodule

FILE: rtl/vlwp_checker.sv
// Port-level assertions for the vector line walker core, bound to the top level.
module vlwp_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 cfg_we,
  input logic [vlwp_pkg::REG_IDX_BITS-1:0]    cfg_index,
  input logic [vlwp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic [55:0]                          in_tdata,
  input logic                                 in_tuser,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((2*COORD_BITS+24+7)/8)*8-1:0] out_tdata,
  input logic                                 out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output transfer changed");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_known_handshake: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tready, out_tvalid}))
    else $error("handshake output unknown");

endmodule

bind vector_line_walker_pincushion_core vlwp_checker #(.COORD_BITS(COORD_BITS)) u_vlwp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
